@@ rtl/lmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmsc_pkg: shared types and tables for the label marching squares cell
// Item structs, per-cell group masks and the point code tables.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsc_pkg;

   localparam int LABEL_W  = 16;
   localparam int COORD_W  = 12;
   localparam int CODE_W   = 3;
   localparam int VNUM_W   = 32;
   localparam int CORNERS  = 4;

   // group mask codes with special lengths
   localparam logic [3:0] MASK_EMPTY  = 4'd0;
   localparam logic [3:0] MASK_FULL   = 4'd15;
   localparam logic [3:0] MASK_DIAG_A = 4'd5;
   localparam logic [3:0] MASK_DIAG_B = 4'd10;

   // group lengths
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FIVE  = 3'd5;

   // point codes P1..P5
   localparam logic [2:0] PT_P1 = 3'd0;
   localparam logic [2:0] PT_P2 = 3'd1;
   localparam logic [2:0] PT_P3 = 3'd2;
   localparam logic [2:0] PT_P4 = 3'd3;
   localparam logic [2:0] PT_P5 = 3'd4;

   typedef struct packed {
      logic               frame_start;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [LABEL_W-1:0] label_x0_y1;
      logic [LABEL_W-1:0] label_x1_y1;
      logic [LABEL_W-1:0] label_x1_y0;
      logic [LABEL_W-1:0] label_x0_y0;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [CODE_W-1:0]  point_code;
      logic [VNUM_W-1:0]  vertex_number;
      logic [VNUM_W-1:0]  center_number;
      logic               is_center;
      logic               last;
   } rsp_type;

   // one cell after grouping: one mask per lane
   typedef struct packed {
      logic                           frame_start;
      logic [COORD_W-1:0]             cell_x;
      logic [COORD_W-1:0]             cell_y;
      logic [CORNERS-1:0][CORNERS-1:0] masks;
   } cell_type;

   function automatic logic [2:0] pts_len(input logic [3:0] mask);
      logic [2:0] len;
      case (mask) inside
         MASK_EMPTY, MASK_FULL:    len = LEN_NONE;
         MASK_DIAG_A, MASK_DIAG_B: len = LEN_FIVE;
         default:                  len = LEN_THREE;
      endcase
      return len;
   endfunction

   // a mask and its complement share a point list
   function automatic logic [2:0] pts_code(input logic [3:0] mask, input logic [2:0] k);
      logic [3:0] m;
      logic [2:0] first;
      logic [2:0] second;
      logic [2:0] code;
      m = mask[3] ? ~mask : mask;
      case (m)
         4'd1:    begin first = PT_P1; second = PT_P2; end
         4'd2:    begin first = PT_P2; second = PT_P3; end
         4'd3:    begin first = PT_P1; second = PT_P3; end
         4'd4:    begin first = PT_P3; second = PT_P4; end
         4'd6:    begin first = PT_P2; second = PT_P4; end
         4'd7:    begin first = PT_P1; second = PT_P4; end
         default: begin first = PT_P1; second = PT_P2; end
      endcase
      if (pts_len(mask) == LEN_FIVE) begin
         code = k;
      end else if (k == 3'd0) begin
         code = first;
      end else if (k == 3'd1) begin
         code = second;
      end else begin
         code = PT_P5;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lmsc_lane.sv @@
// ----------------------------------------------------------------------------
// lmsc_lane: group finder for one corner
// Owns a group when its label is non-zero and no earlier corner shares it.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsc_lane #(
   parameter int LANE     = 0,
   parameter int CMP_BITS = 16
) (
   input  wire logic [lmsc_pkg::CORNERS-1:0][lmsc_pkg::LABEL_W-1:0] labels,
   output logic      [lmsc_pkg::CORNERS-1:0]                         mask
);
   import lmsc_pkg::*;

   logic [CMP_BITS-1:0] own;
   logic                owned;

   always_comb begin
      own   = labels[LANE][CMP_BITS-1:0];
      owned = (own != '0);
      for (int j = 0; j < CORNERS; j++) begin
         if (j < LANE && labels[j][CMP_BITS-1:0] == own) begin
            owned = 1'b0;
         end
      end
      for (int i = 0; i < CORNERS; i++) begin
         mask[i] = owned && (i >= LANE) && (labels[i][CMP_BITS-1:0] == own);
      end
   end

endmodule

`default_nettype wire

@@ rtl/lmsc_emit.sv @@
// ----------------------------------------------------------------------------
// lmsc_emit: vertex emitter
// Walks a cell's groups into an output reg, one vertex a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsc_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cell_valid,
   input  wire lmsc_pkg::cell_type cell_item,
   output logic                    cell_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output lmsc_pkg::rsp_type       rsp_data
);
   import lmsc_pkg::*;

   logic                cur_valid_ff, cur_valid_in;
   cell_type            cur_ff, cur_in;
   logic [1:0]          grp_ff, grp_in;
   logic [2:0]          k_ff, k_in;
   logic [VNUM_W-1:0]   counter_ff, counter_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [CORNERS-1:0][2:0] lens;
   logic [CORNERS-1:0]      nz;
   logic [1:0]              sel;
   logic                    found;
   logic                    more;
   logic                    out_free;
   logic                    emit;
   logic                    at_center;
   logic                    finish;
   logic                    take;
   logic [2:0]              to_center;

   always_comb begin
      for (int g = 0; g < CORNERS; g++) begin
         lens[g] = pts_len(cur_ff.masks[g]);
         nz[g]   = (lens[g] != LEN_NONE);
      end
      // lowest non-empty group at or after the current one
      sel   = grp_ff;
      found = 1'b0;
      for (int g = CORNERS - 1; g >= 0; g--) begin
         if (nz[g] && 2'(g) >= grp_ff) begin
            sel   = 2'(g);
            found = 1'b1;
         end
      end
      more = 1'b0;
      for (int g = 0; g < CORNERS; g++) begin
         if (nz[g] && 2'(g) > sel) begin
            more = 1'b1;
         end
      end
      out_free   = !rsp_valid_ff || !rsp_stall;
      emit       = cur_valid_ff && found && out_free;
      at_center  = (k_ff == lens[sel] - 3'd1);
      to_center  = lens[sel] - 3'd1 - k_ff;
      finish     = (cur_valid_ff && !found) || (emit && at_center && !more);
      cell_ready = !cur_valid_ff || finish;
      take       = cell_valid && cell_ready;
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      grp_in       = grp_ff;
      k_in         = k_ff;
      counter_in   = counter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_x         = cur_ff.cell_x;
         rsp_data_in.out_y         = cur_ff.cell_y;
         rsp_data_in.point_code    = pts_code(cur_ff.masks[sel], k_ff);
         rsp_data_in.vertex_number = counter_ff;
         rsp_data_in.center_number = counter_ff + VNUM_W'(to_center);
         rsp_data_in.is_center     = at_center;
         rsp_data_in.last          = at_center && !more;
         counter_in                = counter_ff + 32'd1;
         if (at_center) begin
            k_in   = 3'd0;
            grp_in = sel + 2'd1;
         end else begin
            k_in = k_ff + 3'd1;
         end
      end

      if (finish) begin
         cur_valid_in = 1'b0;
      end

      // load the next cell; frame start clears the numbering first
      if (take) begin
         cur_valid_in = 1'b1;
         cur_in       = cell_item;
         grp_in       = 2'd0;
         k_in         = 3'd0;
         if (cell_item.frame_start) begin
            counter_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         grp_ff       <= 2'd0;
         k_ff         <= 3'd0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         grp_ff       <= grp_in;
         k_ff         <= k_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (k_ff < LEN_FIVE))
      else $error("vertex index past group length");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (emit && !(take && cell_item.frame_start))
         |=> (counter_ff == $past(counter_ff) + 32'd1))
      else $error("vertex counter did not advance by one");

   a_last_center: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last) |-> rsp_data_ff.is_center)
      else $error("last vertex of a cell is not a center");

   a_center_near: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.center_number - rsp_data_ff.vertex_number) <= 32'd4))
      else $error("center number too far from vertex number");
`endif

endmodule

`default_nettype wire

@@ rtl/label_marching_squares_cell.sv @@
// ----------------------------------------------------------------------------
// label_marching_squares_cell: contour vertices from a 2x2 label cell
// Groups equal non-zero corner labels and emits marching squares vertices.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one cell item: four corner labels, its coordinates and a
//   frame_start flag that restarts vertex numbering at this cell. rsp_* gives
//   one vertex item per cycle unless rsp is stalled: cell coordinates, point
//   code P1..P5, its own number and the number of its group center; last
//   marks a cell's final vertex. Cells with no contour (all background or
//   one label on all four corners) give nothing. The first vertex of a
//   cell passes the input stage, the emitter's cell register and the output
//   register. A cell gives 3 to 12 vertices; the single output register
//   moves one vertex a cycle while rsp is not stalled. A register stage
//   in front of the emitter takes the next cell while the current one drains.
//   Stalling rsp holds the output register; the emitter and then the input
//   stage hold, and req_stall rises. Reset empties both stages and clears the
//   vertex counter to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module label_marching_squares_cell #(
   parameter int LABEL_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lmsc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lmsc_pkg::rsp_type      rsp_data
);
   import lmsc_pkg::*;

   // compare only the low label bits that matter
   localparam int CmpBits = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;

   logic [CORNERS-1:0][LABEL_W-1:0] labels;
   logic [CORNERS-1:0][CORNERS-1:0] lane_masks;

   logic     st1_valid_ff, st1_valid_in;
   cell_type st1_ff, st1_in;
   logic     cell_ready;
   logic     accept;

   assign labels[0] = req_data.label_x0_y1;
   assign labels[1] = req_data.label_x1_y1;
   assign labels[2] = req_data.label_x1_y0;
   assign labels[3] = req_data.label_x0_y0;

   // one lane per corner, each finds the group that corner starts
   for (genvar g = 0; g < CORNERS; g++) begin : g_lane
      lmsc_lane #(
         .LANE     (g),
         .CMP_BITS (CmpBits)
      ) u_lane (
         .labels (labels),
         .mask   (lane_masks[g])
      );
   end

   // input stage: hold while the emitter is busy
   assign req_stall = st1_valid_ff && !cell_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      st1_valid_in = st1_valid_ff && !cell_ready;
      st1_in       = st1_ff;
      if (accept) begin
         st1_valid_in       = 1'b1;
         st1_in.frame_start = req_data.frame_start;
         st1_in.cell_x      = req_data.cell_x;
         st1_in.cell_y      = req_data.cell_y;
         st1_in.masks       = lane_masks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff <= st1_in;
   end

   // merge: walk the lane groups in corner order and number the vertices
   lmsc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (st1_valid_ff),
      .cell_item  (st1_ff),
      .cell_ready (cell_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (st1_valid_ff && !cell_ready) |=> (st1_valid_ff && $stable(st1_ff)))
      else $error("input stage lost a cell while the emitter was busy");

   a_one_owner: assert property (@(posedge clock) disable iff (reset)
      st1_valid_ff |-> ($countones(st1_ff.masks) <= 4))
      else $error("corner claimed by more than one group");

   a_own_bit: assert property (@(posedge clock) disable iff (reset)
      st1_valid_ff |-> ((st1_ff.masks[1][0] == 1'b0) && (st1_ff.masks[2][1:0] == 2'b00)
                        && (st1_ff.masks[3][2:0] == 3'b000)))
      else $error("group mask holds an earlier corner");
`endif

endmodule

`default_nettype wire
